@@ hw/rtl/ffla_pkg.sv @@
// Shared types and constants for the first-fit free-list allocator.
package ffla_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned SIZE_W   = 24;
  // Rounded request plus header never exceeds 2^24 + 16, which fits in 25 bits.
  localparam int unsigned TOTAL_W  = 25;
  localparam int unsigned MIN_SEG  = 24;
  localparam int unsigned HDR_B    = 8;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NULL      = 3'd1,
    STAT_EXHAUSTED = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_UNKNOWN   = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_BASE  = 1'b0,
    CFG_HEAP_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_A_WALK,
    ST_A_EVAL,
    ST_A_DIV_GO,
    ST_A_DIV,
    ST_A_REGION,
    ST_F_SCAN,
    ST_F_WALK,
    ST_F_EVAL,
    ST_F_PLAN,
    ST_UL_RD,
    ST_UL_WR,
    ST_PUSH_A,
    ST_PUSH_B,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              opcode;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic [ADDR_W-1:0] block_bytes;
    logic [2:0]        status;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic [TOTAL_W-1:0] total;
  } region_req_t;

endpackage

@@ hw/rtl/ffla_region.sv @@
// Region sizing unit: rounds a segment size up to whole region multiples.
module ffla_region #(
  parameter int unsigned REGION_BYTES = 4194304,
  localparam int unsigned NW = $clog2((64'd1 << ffla_pkg::TOTAL_W) + REGION_BYTES)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ffla_pkg::region_req_t req_i,
  output logic                  done_o,
  output logic [NW-1:0]         region_o
);
  import ffla_pkg::*;

  // The numerator stays below 2^NW, so a reciprocal with NW + ceil(log2 R) fraction bits
  // gives the exact quotient.
  localparam int unsigned SH    = NW + $clog2(REGION_BYTES);
  localparam int unsigned MW    = NW + 2;
  localparam int unsigned PRW   = NW + MW;
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(REGION_BYTES) - 64'd1) /
                                  64'(REGION_BYTES);

  logic [NW-1:0]  num_q, quo_q, region_q;
  logic [PRW-1:0] prod;
  logic           s1_q, s2_q, done_q;

  assign prod = PRW'(num_q) * PRW'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= req_i.start;
      s2_q   <= s1_q;
      done_q <= s2_q;
    end
  end

  // Round up, divide by multiplying with the reciprocal, then scale back to bytes.
  always_ff @(posedge clk_i) begin
    if (req_i.start) num_q <= NW'(req_i.total) + NW'(REGION_BYTES - 1);
    if (s1_q)        quo_q <= NW'(prod >> SH);
    if (s2_q)        region_q <= quo_q * NW'(REGION_BYTES);
  end

  assign done_o   = done_q;
  assign region_o = region_q;

endmodule

@@ hw/rtl/first_fit_free_list_allocator_core.sv @@
// First-fit free-list allocator: one request at a time, result behind an output register.
//
// The block serves allocate and free transactions one at a time and answers each with one
// result transaction. Free segments live in a doubly linked list held in synchronous
// memories (base, length, next, prev) and allocated blocks in a second memory; occupancy is
// kept in flip-flop used bits, so no clearing pass follows reset. An allocate passes through
// start, walk setup, one evaluation step for each free-list entry walked (up to
// FREE_ENTRIES) and completion; when nothing fits, region sizing and a bump step are added,
// and unlink/push upkeep may follow. A free scans the allocated table at one entry a cycle,
// walks the whole free list (up to FREE_ENTRIES entries) and also passes through start,
// walk setup, planning, upkeep and completion. The memory read port, one access a cycle,
// sets the pace of the walks and the scan; completion also waits while the output
// register holds an unaccepted result. Input stall stays high from acceptance
// until the result is in the output register; a finished result may wait there while the
// next request is taken.
module first_fit_free_list_allocator_core #(
  parameter int unsigned FREE_ENTRIES  = 64,
  parameter int unsigned ALLOC_ENTRIES = 64,
  parameter int unsigned REGION_BYTES  = 4194304
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  ffla_pkg::req_t                       in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output ffla_pkg::rsp_t                       out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [ffla_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ffla_pkg::ADDR_W-1:0]          cfg_wdata_i
);
  import ffla_pkg::*;

  localparam int unsigned IW = $clog2(FREE_ENTRIES);
  localparam int unsigned PW = IW + 1;
  localparam int unsigned AW = $clog2(ALLOC_ENTRIES);
  localparam int unsigned NW = $clog2((64'd1 << TOTAL_W) + REGION_BYTES);
  localparam logic [PW-1:0] NONE = PW'(FREE_ENTRIES);

  // Free segment memories and their registered read data.
  logic [ADDR_W-1:0] fbase_mem [FREE_ENTRIES];
  logic [ADDR_W-1:0] flen_mem  [FREE_ENTRIES];
  logic [PW-1:0]     fnext_mem [FREE_ENTRIES];
  logic [PW-1:0]     fprev_mem [FREE_ENTRIES];
  logic [ADDR_W-1:0] f_rd_base_q, f_rd_len_q;
  logic [PW-1:0]     f_rd_next_q, f_rd_prev_q;
  logic [IW-1:0]     f_raddr;

  logic              fbase_we, fnext_we, fprev_we;
  logic [IW-1:0]     fbase_wa, fnext_wa, fprev_wa;
  logic [ADDR_W-1:0] fbase_wd, flen_wd;
  logic [PW-1:0]     fnext_wd, fprev_wd;

  // Allocated block memory.
  logic [ADDR_W-1:0] abase_mem [ALLOC_ENTRIES];
  logic [ADDR_W-1:0] alen_mem  [ALLOC_ENTRIES];
  logic [ADDR_W-1:0] a_rd_base_q, a_rd_len_q;

  logic [FREE_ENTRIES-1:0]  free_used_q;
  logic [ALLOC_ENTRIES-1:0] alloc_used_q;
  logic [PW-1:0]            head_q;
  logic [ADDR_W-1:0]        heap_limit_q, next_region_q;

  state_e state_q, state_d;
  req_t   req_q;

  logic [TOTAL_W-1:0] total_q;
  logic [AW-1:0]      a_q;
  logic [IW-1:0]      idx_q;
  logic [IW-1:0]      steps_q;
  logic [ADDR_W-1:0]  cur_base_q, cur_len_q;

  logic [AW:0]        ai_q;
  logic               pv_q;
  logic [AW-1:0]      pidx_q;

  logic               left_v_q, right_v_q;
  logic [IW-1:0]      left_i_q, right_i_q;
  logic [ADDR_W-1:0]  lb_q, ll_q, rl_q;

  logic               ul0_v_q, ul1_v_q;
  logic [IW-1:0]      ul0_i_q, ul1_i_q;
  logic               push_v_q;
  logic [IW-1:0]      push_i_q;
  logic [ADDR_W-1:0]  push_base_q, push_len_q;
  logic               fclr_v_q;
  logic [IW-1:0]      fclr_i_q;

  status_e            res_status_q;
  logic [ADDR_W-1:0]  res_addr_q, res_bytes_q;

  rsp_t               out_q;
  logic               out_valid_q;

  // Priority encoders over the used bits.
  logic          fs_found, as_found;
  logic [IW-1:0] fs_idx;
  logic [AW-1:0] as_idx;

  always_comb begin
    fs_found = 1'b0;
    fs_idx   = '0;
    for (int i = FREE_ENTRIES - 1; i >= 0; i--) begin
      if (!free_used_q[i]) begin
        fs_found = 1'b1;
        fs_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    as_found = 1'b0;
    as_idx   = '0;
    for (int i = ALLOC_ENTRIES - 1; i >= 0; i--) begin
      if (!alloc_used_q[i]) begin
        as_found = 1'b1;
        as_idx   = AW'(i);
      end
    end
  end

  // Region sizing unit for bump allocation.
  region_req_t      rg_req;
  logic             rg_done;
  logic [NW-1:0]    region;

  assign rg_req.start = (state_q == ST_A_DIV_GO);
  assign rg_req.total = total_q;

  ffla_region #(.REGION_BYTES(REGION_BYTES)) u_region (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (rg_req),
    .done_o  (rg_done),
    .region_o(region)
  );

  // Combinational helpers of the evaluation states.
  logic              a_fit, a_split, a_cont, f_cont;
  logic [ADDR_W-1:0] a_rest;
  logic              a_match, scan_last;
  logic              l_hit, r_hit;
  logic [ADDR_W:0]   end33, lim33;
  logic              exhausted;
  logic [NW-1:0]     region_rest;
  logic              region_push;
  logic              r_eff, plan_full, plan_ul;
  logic [IW-1:0]     plan_slot;
  logic [ADDR_W-1:0] plan_nb, plan_nl;
  logic              done_go;
  logic              ul_more;

  always_comb begin
    a_fit     = f_rd_len_q >= ADDR_W'(total_q);
    a_rest    = f_rd_len_q - ADDR_W'(total_q);
    a_split   = a_rest >= ADDR_W'(MIN_SEG);
    a_cont    = (f_rd_next_q != NONE) && (steps_q != IW'(FREE_ENTRIES - 1));
    f_cont    = a_cont;
    a_match   = pv_q && alloc_used_q[pidx_q] &&
                ((a_rd_base_q + ADDR_W'(HDR_B)) == req_q.block_address);
    scan_last = pv_q && (pidx_q == AW'(ALLOC_ENTRIES - 1));
    l_hit     = (f_rd_base_q + f_rd_len_q) == cur_base_q;
    r_hit     = (cur_base_q + cur_len_q) == f_rd_base_q;

    end33       = {1'b0, next_region_q} + (ADDR_W + 1)'(region);
    lim33       = {1'b0, heap_limit_q} + (ADDR_W + 1)'(1);
    exhausted   = (next_region_q > heap_limit_q) || (end33 > lim33);
    region_rest = region - NW'(total_q);
    region_push = (region_rest >= NW'(MIN_SEG)) && fs_found;

    // A single entry that touches both sides counts as the left neighbor only.
    r_eff     = right_v_q && !(left_v_q && (left_i_q == right_i_q));
    plan_full = !left_v_q && !r_eff && !fs_found;
    plan_ul   = left_v_q || r_eff;
    if (left_v_q) begin
      plan_slot = left_i_q;
      plan_nb   = lb_q;
      plan_nl   = ll_q + cur_len_q + (r_eff ? rl_q : '0);
    end else if (r_eff) begin
      plan_slot = right_i_q;
      plan_nb   = cur_base_q;
      plan_nl   = cur_len_q + rl_q;
    end else begin
      plan_slot = fs_idx;
      plan_nb   = cur_base_q;
      plan_nl   = cur_len_q;
    end

    done_go = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
    ul_more = ul0_v_q && ul1_v_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_START;
      ST_START: begin
        if (req_q.opcode == OP_ALLOC) begin
          if (req_q.request_size == '0 || !as_found) state_d = ST_DONE;
          else                                       state_d = ST_A_WALK;
        end else begin
          if (req_q.block_address == '0) state_d = ST_DONE;
          else                           state_d = ST_F_SCAN;
        end
      end
      ST_A_WALK:   state_d = (head_q == NONE) ? ST_A_DIV_GO : ST_A_EVAL;
      ST_A_EVAL: begin
        if (a_fit)        state_d = ST_UL_RD;
        else if (!a_cont) state_d = ST_A_DIV_GO;
      end
      ST_A_DIV_GO: state_d = ST_A_DIV;
      ST_A_DIV:    if (rg_done) state_d = ST_A_REGION;
      ST_A_REGION: state_d = (!exhausted && region_push) ? ST_PUSH_A : ST_DONE;
      ST_F_SCAN: begin
        if (a_match)        state_d = ST_F_WALK;
        else if (scan_last) state_d = ST_DONE;
      end
      ST_F_WALK:   state_d = (head_q == NONE) ? ST_F_PLAN : ST_F_EVAL;
      ST_F_EVAL:   if (!f_cont) state_d = ST_F_PLAN;
      ST_F_PLAN: begin
        if (plan_full)    state_d = ST_DONE;
        else if (plan_ul) state_d = ST_UL_RD;
        else              state_d = ST_PUSH_A;
      end
      ST_UL_RD:    state_d = ST_UL_WR;
      ST_UL_WR: begin
        if (ul_more)       state_d = ST_UL_RD;
        else if (push_v_q) state_d = ST_PUSH_A;
        else               state_d = ST_DONE;
      end
      ST_PUSH_A:   state_d = ST_PUSH_B;
      ST_PUSH_B:   state_d = ST_DONE;
      ST_DONE:     if (done_go) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Memory port controls.
  always_comb begin
    f_raddr  = '0;
    fbase_we = 1'b0;
    fbase_wa = push_i_q;
    fbase_wd = push_base_q;
    flen_wd  = push_len_q;
    fnext_we = 1'b0;
    fnext_wa = '0;
    fnext_wd = '0;
    fprev_we = 1'b0;
    fprev_wa = '0;
    fprev_wd = '0;
    unique case (state_q)
      ST_A_WALK, ST_F_WALK: f_raddr = head_q[IW-1:0];
      ST_A_EVAL, ST_F_EVAL: f_raddr = f_rd_next_q[IW-1:0];
      ST_UL_RD:             f_raddr = ul0_v_q ? ul0_i_q : ul1_i_q;
      ST_UL_WR: begin
        // Splice the neighbors of the entry around it.
        fnext_we = (f_rd_prev_q != NONE);
        fnext_wa = f_rd_prev_q[IW-1:0];
        fnext_wd = f_rd_next_q;
        fprev_we = (f_rd_next_q != NONE);
        fprev_wa = f_rd_next_q[IW-1:0];
        fprev_wd = f_rd_prev_q;
      end
      ST_PUSH_A: begin
        fbase_we = 1'b1;
        fnext_we = 1'b1;
        fnext_wa = push_i_q;
        fnext_wd = head_q;
        fprev_we = 1'b1;
        fprev_wa = push_i_q;
        fprev_wd = NONE;
      end
      ST_PUSH_B: begin
        fprev_we = (head_q != NONE);
        fprev_wa = head_q[IW-1:0];
        fprev_wd = PW'(push_i_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fbase_we) begin
      fbase_mem[fbase_wa] <= fbase_wd;
      flen_mem[fbase_wa]  <= flen_wd;
    end
    if (fnext_we) fnext_mem[fnext_wa] <= fnext_wd;
    if (fprev_we) fprev_mem[fprev_wa] <= fprev_wd;
    f_rd_base_q <= fbase_mem[f_raddr];
    f_rd_len_q  <= flen_mem[f_raddr];
    f_rd_next_q <= fnext_mem[f_raddr];
    f_rd_prev_q <= fprev_mem[f_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (done_go && req_q.opcode == OP_ALLOC && res_status_q == STAT_OK) begin
      abase_mem[a_q] <= cur_base_q;
      alen_mem[a_q]  <= res_bytes_q;
    end
    a_rd_base_q <= abase_mem[ai_q[AW-1:0]];
    a_rd_len_q  <= alen_mem[ai_q[AW-1:0]];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      free_used_q   <= '0;
      alloc_used_q  <= '0;
      head_q        <= NONE;
      heap_limit_q  <= 32'hFFFF_FFFF;
      next_region_q <= 32'h1000_0000;
      out_valid_q   <= 1'b0;
      pv_q          <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= (state_q == ST_F_SCAN) && (ai_q < (AW + 1)'(ALLOC_ENTRIES));

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_HEAP_BASE:  next_region_q <= cfg_wdata_i;
          CFG_HEAP_LIMIT: heap_limit_q  <= cfg_wdata_i;
          default: ;
        endcase
      end else if (state_q == ST_A_REGION && !exhausted) begin
        // Saturate the bump pointer when a region ends at the top of memory.
        next_region_q <= end33[ADDR_W] ? '1 : end33[ADDR_W-1:0];
      end

      if (state_q == ST_UL_WR && f_rd_prev_q == NONE) head_q <= f_rd_next_q;
      if (state_q == ST_PUSH_B) begin
        head_q                <= PW'(push_i_q);
        free_used_q[push_i_q] <= 1'b1;
      end

      if (done_go && res_status_q == STAT_OK) begin
        if (fclr_v_q) free_used_q[fclr_i_q] <= 1'b0;
        alloc_used_q[a_q] <= (req_q.opcode == OP_ALLOC);
      end

      if (done_go)                         out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Request datapath.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        req_q <= in_data_i;
      end
      ST_START: begin
        total_q      <= (((TOTAL_W'(req_q.request_size) + TOTAL_W'(7)) & ~TOTAL_W'(7))
                         + TOTAL_W'(HDR_B) < TOTAL_W'(MIN_SEG)) ? TOTAL_W'(MIN_SEG) :
                        ((TOTAL_W'(req_q.request_size) + TOTAL_W'(7)) & ~TOTAL_W'(7))
                         + TOTAL_W'(HDR_B);
        a_q          <= as_idx;
        ai_q         <= '0;
        ul0_v_q      <= 1'b0;
        ul1_v_q      <= 1'b0;
        push_v_q     <= 1'b0;
        fclr_v_q     <= 1'b0;
        left_v_q     <= 1'b0;
        right_v_q    <= 1'b0;
        res_status_q <= STAT_OK;
        res_addr_q   <= '0;
        res_bytes_q  <= '0;
        if (req_q.opcode == OP_ALLOC) begin
          if (req_q.request_size == '0) res_status_q <= STAT_NULL;
          else if (!as_found)           res_status_q <= STAT_FULL;
        end else if (req_q.block_address == '0) begin
          res_status_q <= STAT_NULL;
        end
      end
      ST_A_WALK, ST_F_WALK: begin
        idx_q   <= head_q[IW-1:0];
        steps_q <= '0;
      end
      ST_A_EVAL: begin
        if (a_fit) begin
          cur_base_q <= f_rd_base_q;
          res_addr_q <= f_rd_base_q + ADDR_W'(HDR_B);
          ul0_v_q    <= 1'b1;
          ul0_i_q    <= idx_q;
          if (a_split) begin
            // Put the remainder back at the head.
            push_v_q    <= 1'b1;
            push_i_q    <= idx_q;
            push_base_q <= f_rd_base_q + ADDR_W'(total_q);
            push_len_q  <= a_rest;
            res_bytes_q <= ADDR_W'(total_q);
          end else begin
            fclr_v_q    <= 1'b1;
            fclr_i_q    <= idx_q;
            res_bytes_q <= f_rd_len_q;
          end
        end else if (a_cont) begin
          idx_q   <= f_rd_next_q[IW-1:0];
          steps_q <= steps_q + IW'(1);
        end
      end
      ST_A_REGION: begin
        if (exhausted) begin
          res_status_q <= STAT_EXHAUSTED;
        end else begin
          cur_base_q <= next_region_q;
          res_addr_q <= next_region_q + ADDR_W'(HDR_B);
          if (region_push) begin
            push_v_q    <= 1'b1;
            push_i_q    <= fs_idx;
            push_base_q <= next_region_q + ADDR_W'(total_q);
            push_len_q  <= ADDR_W'(region_rest);
            res_bytes_q <= ADDR_W'(total_q);
          end else begin
            res_bytes_q <= ADDR_W'(region);
          end
        end
      end
      ST_F_SCAN: begin
        if (ai_q < (AW + 1)'(ALLOC_ENTRIES)) ai_q <= ai_q + (AW + 1)'(1);
        pidx_q <= ai_q[AW-1:0];
        if (a_match) begin
          a_q        <= pidx_q;
          cur_base_q <= a_rd_base_q;
          cur_len_q  <= a_rd_len_q;
        end else if (scan_last) begin
          res_status_q <= STAT_UNKNOWN;
        end
      end
      ST_F_EVAL: begin
        // Keep the last match on each side in list order.
        if (l_hit) begin
          left_v_q <= 1'b1;
          left_i_q <= idx_q;
          lb_q     <= f_rd_base_q;
          ll_q     <= f_rd_len_q;
        end
        if (r_hit) begin
          right_v_q <= 1'b1;
          right_i_q <= idx_q;
          rl_q      <= f_rd_len_q;
        end
        if (f_cont) begin
          idx_q   <= f_rd_next_q[IW-1:0];
          steps_q <= steps_q + IW'(1);
        end
      end
      ST_F_PLAN: begin
        if (plan_full) begin
          res_status_q <= STAT_FULL;
        end else begin
          ul0_v_q     <= plan_ul;
          ul0_i_q     <= left_v_q ? left_i_q : right_i_q;
          ul1_v_q     <= left_v_q && r_eff;
          ul1_i_q     <= right_i_q;
          fclr_v_q    <= left_v_q && r_eff;
          fclr_i_q    <= right_i_q;
          push_v_q    <= 1'b1;
          push_i_q    <= plan_slot;
          push_base_q <= plan_nb;
          push_len_q  <= plan_nl;
          res_bytes_q <= plan_nl;
        end
      end
      ST_UL_WR: begin
        if (ul0_v_q) ul0_v_q <= 1'b0;
        else         ul1_v_q <= 1'b0;
      end
      default: ;
    endcase
  end

  // Output register: hold the result until the consumer takes it.
  always_ff @(posedge clk_i) begin
    if (done_go) begin
      out_q.status         <= res_status_q;
      out_q.result_address <= (res_status_q == STAT_OK && req_q.opcode == OP_ALLOC) ?
                              res_addr_q : '0;
      out_q.block_bytes    <= (res_status_q == STAT_OK) ? res_bytes_q : '0;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A non-empty list head always names a live entry between requests.
  a_head_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && head_q != NONE) |-> free_used_q[head_q[IW-1:0]])
    else $error("list head names an unused free entry");

  // An accepted request always leaves idle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_START))
    else $error("accepted request did not start");

  // A new result only appears out of the completion state.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside completion");

  // The sizing unit finishes only while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rg_done |-> (state_q == ST_A_DIV))
    else $error("region unit finished unexpectedly");

endmodule
